// File: hw/rtl/arl_pkg.sv
// ============================================================================
// arl_pkg
// Shared types and constants for the address ring table lookup block.
// ============================================================================
package arl_pkg;

  localparam int ADDR_W            = 48;
  localparam int SLOT_W            = 8;
  localparam int NUM_SLOTS_DEFAULT = 256;

  typedef enum logic [1:0] {
    OUTCOME_MATCHED   = 2'd0,
    OUTCOME_ALLOCATED = 2'd1,
    OUTCOME_NONE      = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } scan_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] lookup_address;
    logic              create_if_missing;
  } req_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

endpackage

// File: hw/rtl/arl_slot_mem.sv
// ============================================================================
// arl_slot_mem
// Slot address store: one write port, one read port, registered read data.
// ============================================================================
module arl_slot_mem
  import arl_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
  localparam int IDX_W    = $clog2(NUM_SLOTS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [ADDR_W-1:0] wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output logic [ADDR_W-1:0] rdata
);

  logic [ADDR_W-1:0] mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/arl_scan_ctrl.sv
// ============================================================================
// arl_scan_ctrl
// Backward scan over the filled slots, newest first, with ring allocation.
// Slots fill in ring order and never go invalid, so a fill count stands in
// for the per-slot valid bits.
// ============================================================================
module arl_scan_ctrl
  import arl_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
  localparam int IDX_W    = $clog2(NUM_SLOTS),
  localparam int CNT_W    = $clog2(NUM_SLOTS + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_SLOTS);

  scan_state_t       state, state_next;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] req_addr;
  logic              req_create;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  left;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [ADDR_W-1:0] rdata;

  logic accept;
  logic issue;
  logic hit;
  logic finish_miss;
  logic mem_we;

  arl_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (head),
    .wdata (req_addr),
    .re    (issue),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    issue       = 1'b0;
    hit         = 1'b0;
    finish_miss = 1'b0;
    mem_we      = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        hit = pend && (rdata == req_addr);
        if (hit) begin
          state_next = S_DONE;
        end else if ((left == '0) && !pend) begin
          finish_miss = 1'b1;
          mem_we      = req_create;
          state_next  = S_DONE;
        end else begin
          issue = (left != '0);
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign accept = req_ready && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (finish_miss && req_create) begin
        head <= (head == LAST_IDX) ? '0 : head + 1'b1;
        if (fill != FULL_CNT) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= rd_idx;
    if (accept) begin
      req_addr   <= req.lookup_address;
      req_create <= req.create_if_missing;
      rd_idx     <= (head == '0) ? LAST_IDX : head - 1'b1;
      left       <= fill;
    end else if (issue) begin
      rd_idx <= (rd_idx == '0) ? LAST_IDX : rd_idx - 1'b1;
      left   <= left - 1'b1;
    end
    if (hit) begin
      res.outcome    <= OUTCOME_MATCHED;
      res.slot_index <= SLOT_W'(pend_idx);
    end else if (finish_miss) begin
      if (req_create) begin
        res.outcome    <= OUTCOME_ALLOCATED;
        res.slot_index <= SLOT_W'(head);
      end else begin
        res.outcome    <= OUTCOME_NONE;
        res.slot_index <= '0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count above table size");

  a_head_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != FULL_CNT) |-> (head == IDX_W'(fill)))
    else $error("ring pointer out of step with fill count");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (fill == $past(fill) + 1'b1) || (fill == FULL_CNT))
    else $error("allocation did not advance fill count");

  a_none_zero_idx: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.outcome == OUTCOME_NONE)) |-> (res.slot_index == '0))
    else $error("no-match result carries a slot index");

endmodule

// File: hw/rtl/address_ring_table_lookup.sv
// ============================================================================
// address_ring_table_lookup
// Associative table of network-address slots with ring allocation.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req): one word per lookup, carrying a
// 48-bit address and a create flag. Response channel (rsp_valid/rsp_ready/
// rsp): one word per request with the outcome and slot index.
// The filled slots are read from the address memory one per cycle, newest
// first, through its single read port; the first equal address ends the
// scan. A miss with create set writes the slot under the ring pointer.
// One request is processed at a time. With F filled slots (at most
// NUM_SLOTS) a request reads up to F slots between acceptance and the
// response register, fewer on an early hit. The next request is taken
// only after the result of the last has left the scan engine.
// Reset empties the table (fill count and ring pointer to zero) at once;
// there is no clearing pass. The response register frees the scan engine,
// so a new request is taken while a response waits; with the register
// still full a finished result is held until rsp_ready.
// ============================================================================
module address_ring_table_lookup
  import arl_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic res_valid;
  logic res_ready;
  rsp_t res;

  arl_scan_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
